/* rtl/swrl_pkg.sv */
package swrl_pkg;

  // Slots held in the counter store.
  localparam int SLOTS = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int NOW_W = 48;
  localparam int CNT32_W = 32;
  // Window length in ms fits here for any 6-bit window_seconds.
  localparam int WIN_W = 16;
  localparam int MS_PER_SEC = 1000;

  typedef logic [1:0] op_t;
  localparam op_t OP_CHECK = 2'd0;
  localparam op_t OP_READ = 2'd1;
  localparam op_t OP_SET = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WINDOW_SECONDS = 2'd0;
  localparam reg_idx_t REG_SLOT_MS = 2'd1;
  localparam reg_idx_t REG_SLOTS_USED = 2'd2;
  localparam reg_idx_t REG_REQUEST_LIMIT = 2'd3;

endpackage

/* rtl/sliding_window_rate_limiter.sv */
// Channel   Direction  Handshake             Beat
// in        input      in_valid / in_stall   in_operation, in_now_ms, in_set_value
// out       output     out_valid / out_stall out_drop, out_window_count
// cfg       input      APB psel / penable    paddr, pwdata, prdata
//
// One item is worked at a time. A set with value zero skips the divider and the sweep. Any
// other item runs through the one-bit-a-cycle divider (the 48-bit time mod the window,
// then 16 bits for the slot index), then one pass over the n slots in use of the
// slot memory that zeroes, updates and sums slots at one entry a cycle.
// Reset marks every slot empty through per-slot valid bits; no clearing pass is run.
// A result waits in the output register while out_stall is high; the next item is
// taken meanwhile and holds at its last cycle until that register is free.
module sliding_window_rate_limiter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  swrl_pkg::op_t                 in_operation,
  input  logic [swrl_pkg::NOW_W-1:0]    in_now_ms,
  input  logic [31:0]                   in_set_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_drop,
  output logic [31:0]                   out_window_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import swrl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DECIDE,
    S_SWEEP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [5:0]  window_seconds_r, window_seconds_nxt;
  logic [15:0] slot_ms_r, slot_ms_nxt;
  logic [6:0]  slots_used_r, slots_used_nxt;
  logic [31:0] request_limit_r, request_limit_nxt;

  // Window state kept outside the slot memory.
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic              started_r, started_nxt;
  logic [NOW_W-1:0]  last_time_r, last_time_nxt;
  logic [SLOT_W-1:0] last_slot_r, last_slot_nxt;

  // Item in flight.
  op_t               op_r, op_nxt;
  logic [NOW_W-1:0]  now_r, now_nxt;
  logic [31:0]       amount_r, amount_nxt;
  logic [NOW_W-1:0]  elapsed_r, elapsed_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [WIN_W-1:0]  per_r, per_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  first_r, first_nxt;

  // Shared restoring divider.
  logic [NOW_W-1:0]  div_q_r, div_q_nxt;
  logic [WIN_W-1:0]  div_rem_r, div_rem_nxt;
  logic [WIN_W-1:0]  div_den_r, div_den_nxt;
  logic [5:0]        div_cnt_r, div_cnt_nxt;
  logic              div_phase_r, div_phase_nxt;
  logic              div_done_r, div_done_nxt;
  logic [WIN_W:0]    div_trial;
  logic [WIN_W:0]    div_diff;
  logic              div_ge;
  logic [WIN_W-1:0]  div_rem_step;
  logic [NOW_W-1:0]  div_q_step;

  // Sweep over the slots.
  logic              mode_add_r, mode_add_nxt;
  logic              zero_en_r, zero_en_nxt;
  logic [SLOT_W-1:0] zlo_r, zlo_nxt;
  logic [SLOT_W-1:0] tgt_r, tgt_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              p1_v_r, p1_v_nxt;
  logic [SLOT_W-1:0] p1_idx_r, p1_idx_nxt;
  logic              p1_ok_r, p1_ok_nxt;
  logic              p2_v_r, p2_v_nxt;
  logic [31:0]       p2_val_r, p2_val_nxt;
  logic [31:0]       acc_r, acc_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_drop_r, out_drop_nxt;
  logic [31:0]       out_count_r, out_count_nxt;

  // Memory port.
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  // Datapath helpers.
  logic              in_accept;
  logic              cfg_write;
  logic [5:0]        ws_eff;
  logic [15:0]       per_eff;
  logic [CNT_W-1:0]  n_eff;
  logic [SLOT_W-1:0] quot_idx;
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] n_last;
  logic              full_clear;
  logic              slot_moved;
  logic [31:0]       old_val;
  logic [32:0]       add_sum;
  logic [31:0]       add_sat;
  logic              in_zero;
  logic [31:0]       new_val;
  logic [32:0]       acc_sum;

  swrl_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_drop         = out_drop_r;
  assign out_window_count = out_count_r;

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_SECONDS: prdata = 32'(window_seconds_r);
      REG_SLOT_MS:        prdata = 32'(slot_ms_r);
      REG_SLOTS_USED:     prdata = 32'(slots_used_r);
      REG_REQUEST_LIMIT:  prdata = request_limit_r;
      default:            prdata = '0;
    endcase
  end

  // Zero registers act as one; slots_used is capped at the store size.
  assign ws_eff  = (window_seconds_r == '0) ? 6'd1 : window_seconds_r;
  assign per_eff = (slot_ms_r == '0) ? 16'd1 : slot_ms_r;
  assign n_eff   = (slots_used_r == '0) ? CNT_W'(1) :
                   (32'(slots_used_r) > 32'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slots_used_r);

  assign div_trial    = {div_rem_r, div_q_r[NOW_W-1]};
  assign div_diff     = div_trial - {1'b0, div_den_r};
  assign div_ge       = (div_trial >= {1'b0, div_den_r});
  assign div_rem_step = div_ge ? div_diff[WIN_W-1:0] : div_trial[WIN_W-1:0];
  assign div_q_step   = {div_q_r[NOW_W-2:0], div_ge};

  assign n_last   = SLOT_W'(n_r - CNT_W'(1));
  assign quot_idx = (div_q_r[WIN_W-1:0] >= WIN_W'(n_r)) ? n_last
                                                         : div_q_r[SLOT_W-1:0];
  assign cur_slot = (CNT_W'(last_slot_r) < n_r) ? last_slot_r : n_last;
  assign full_clear = !started_r || (elapsed_r >= NOW_W'(win_r));
  assign slot_moved = (elapsed_r >= NOW_W'(per_r));

  assign old_val = p1_ok_r ? ram_rdata : '0;
  assign add_sum = {1'b0, old_val} + {1'b0, amount_r};
  assign add_sat = add_sum[32] ? '1 : add_sum[31:0];
  // Slots strictly after the old slot and before the new one, wrapping at n.
  assign in_zero = zero_en_r &&
                   ((zlo_r <= tgt_r) ? (p1_idx_r >= zlo_r && p1_idx_r < tgt_r)
                                     : (p1_idx_r >= zlo_r || p1_idx_r < tgt_r));

  always_comb begin
    if (mode_add_r) begin
      new_val = (p1_idx_r == tgt_r) ? add_sat : old_val;
    end else if (p1_idx_r == tgt_r) begin
      new_val = amount_r;
    end else begin
      new_val = in_zero ? '0 : old_val;
    end
  end

  assign acc_sum = {1'b0, acc_r} + {1'b0, p2_val_r};

  always_comb begin
    state_nxt          = state_r;
    window_seconds_nxt = window_seconds_r;
    slot_ms_nxt        = slot_ms_r;
    slots_used_nxt     = slots_used_r;
    request_limit_nxt  = request_limit_r;
    valid_nxt          = valid_r;
    started_nxt        = started_r;
    last_time_nxt      = last_time_r;
    last_slot_nxt      = last_slot_r;
    op_nxt             = op_r;
    now_nxt            = now_r;
    amount_nxt         = amount_r;
    elapsed_nxt        = elapsed_r;
    win_nxt            = win_r;
    per_nxt            = per_r;
    n_nxt              = n_r;
    first_nxt          = first_r;
    div_q_nxt          = div_q_r;
    div_rem_nxt        = div_rem_r;
    div_den_nxt        = div_den_r;
    div_cnt_nxt        = div_cnt_r;
    div_phase_nxt      = div_phase_r;
    div_done_nxt       = div_done_r;
    mode_add_nxt       = mode_add_r;
    zero_en_nxt        = zero_en_r;
    zlo_nxt            = zlo_r;
    tgt_nxt            = tgt_r;
    rd_idx_nxt         = rd_idx_r;
    p1_v_nxt           = 1'b0;
    p1_idx_nxt         = p1_idx_r;
    p1_ok_nxt          = p1_ok_r;
    p2_v_nxt           = 1'b0;
    p2_val_nxt         = p2_val_r;
    acc_nxt            = acc_r;
    out_valid_nxt      = out_valid_r;
    out_drop_nxt       = out_drop_r;
    out_count_nxt      = out_count_r;
    ram_we             = 1'b0;
    ram_waddr          = p1_idx_r;
    ram_wdata          = new_val;
    ram_re             = 1'b0;
    ram_raddr          = rd_idx_r[SLOT_W-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_write) begin
      unique case (paddr[3:2])
        REG_WINDOW_SECONDS: window_seconds_nxt = pwdata[5:0];
        REG_SLOT_MS:        slot_ms_nxt = pwdata[15:0];
        REG_SLOTS_USED:     slots_used_nxt = pwdata[6:0];
        REG_REQUEST_LIMIT:  request_limit_nxt = pwdata;
        default:            request_limit_nxt = request_limit_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt      = in_operation;
          now_nxt     = in_now_ms;
          elapsed_nxt = in_now_ms - last_time_r;
          win_nxt     = WIN_W'(32'(ws_eff) * MS_PER_SEC);
          per_nxt     = per_eff;
          n_nxt       = n_eff;
          first_nxt   = CNT_W'(last_slot_r) + CNT_W'(1);
          if (in_operation == OP_CHECK) begin
            amount_nxt = 32'd1;
          end else if (in_operation == OP_SET) begin
            amount_nxt = in_set_value;
          end else begin
            amount_nxt = '0;
          end
          if (in_operation == OP_SET && in_set_value == '0) begin
            valid_nxt   = '0;
            started_nxt = 1'b0;
            acc_nxt     = '0;
            state_nxt   = S_FIN;
          end else begin
            div_q_nxt     = in_now_ms;
            div_rem_nxt   = '0;
            div_den_nxt   = WIN_W'(32'(ws_eff) * MS_PER_SEC);
            div_cnt_nxt   = 6'(NOW_W - 1);
            div_phase_nxt = 1'b0;
            div_done_nxt  = 1'b0;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        // Slot after the last one, reduced modulo n by repeated subtraction.
        if (first_r >= n_r) begin
          first_nxt = first_r - n_r;
        end
        if (!div_done_r) begin
          div_q_nxt   = div_q_step;
          div_rem_nxt = div_rem_step;
          div_cnt_nxt = div_cnt_r - 6'd1;
          if (div_cnt_r == '0) begin
            if (!div_phase_r) begin
              // Remainder by the window becomes the dividend by the slot period.
              div_q_nxt     = {div_rem_step, {(NOW_W - WIN_W){1'b0}}};
              div_rem_nxt   = '0;
              div_den_nxt   = per_r;
              div_cnt_nxt   = 6'(WIN_W - 1);
              div_phase_nxt = 1'b1;
            end else begin
              div_done_nxt = 1'b1;
            end
          end
        end else if (first_r < n_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        acc_nxt    = '0;
        rd_idx_nxt = '0;
        zlo_nxt    = first_r[SLOT_W-1:0];
        if (full_clear) begin
          valid_nxt     = '0;
          started_nxt   = 1'b1;
          last_time_nxt = now_r;
          last_slot_nxt = quot_idx;
          mode_add_nxt  = 1'b0;
          zero_en_nxt   = 1'b0;
          tgt_nxt       = quot_idx;
        end else if (slot_moved) begin
          last_time_nxt = now_r;
          last_slot_nxt = quot_idx;
          mode_add_nxt  = 1'b0;
          zero_en_nxt   = 1'b1;
          tgt_nxt       = quot_idx;
        end else begin
          mode_add_nxt = 1'b1;
          zero_en_nxt  = 1'b0;
          tgt_nxt      = cur_slot;
        end
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (rd_idx_r < n_r) begin
          ram_re     = 1'b1;
          p1_v_nxt   = 1'b1;
          p1_idx_nxt = rd_idx_r[SLOT_W-1:0];
          p1_ok_nxt  = valid_r[rd_idx_r[SLOT_W-1:0]];
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (p1_v_r) begin
          ram_we              = 1'b1;
          valid_nxt[p1_idx_r] = 1'b1;
          p2_v_nxt            = 1'b1;
          p2_val_nxt          = new_val;
        end
        if (p2_v_r) begin
          acc_nxt = acc_sum[32] ? '1 : acc_sum[31:0];
        end
        if (rd_idx_r == n_r && !p1_v_r && !p2_v_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_drop_nxt  = (op_r == OP_CHECK) && (acc_r > request_limit_r);
          out_count_nxt = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      window_seconds_r <= 6'd10;
      slot_ms_r        <= 16'd200;
      slots_used_r     <= 7'd50;
      request_limit_r  <= '0;
      valid_r          <= '0;
      started_r        <= 1'b0;
      last_time_r      <= '0;
      last_slot_r      <= '0;
      div_done_r       <= 1'b0;
      p1_v_r           <= 1'b0;
      p2_v_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      window_seconds_r <= window_seconds_nxt;
      slot_ms_r        <= slot_ms_nxt;
      slots_used_r     <= slots_used_nxt;
      request_limit_r  <= request_limit_nxt;
      valid_r          <= valid_nxt;
      started_r        <= started_nxt;
      last_time_r      <= last_time_nxt;
      last_slot_r      <= last_slot_nxt;
      div_done_r       <= div_done_nxt;
      p1_v_r           <= p1_v_nxt;
      p2_v_r           <= p2_v_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    now_r       <= now_nxt;
    amount_r    <= amount_nxt;
    elapsed_r   <= elapsed_nxt;
    win_r       <= win_nxt;
    per_r       <= per_nxt;
    n_r         <= n_nxt;
    first_r     <= first_nxt;
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    div_den_r   <= div_den_nxt;
    div_cnt_r   <= div_cnt_nxt;
    div_phase_r <= div_phase_nxt;
    mode_add_r  <= mode_add_nxt;
    zero_en_r   <= zero_en_nxt;
    zlo_r       <= zlo_nxt;
    tgt_r       <= tgt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    p1_idx_r    <= p1_idx_nxt;
    p1_ok_r     <= p1_ok_nxt;
    p2_val_r    <= p2_val_nxt;
    acc_r       <= acc_nxt;
    out_drop_r  <= out_drop_nxt;
    out_count_r <= out_count_nxt;
  end

`ifndef ASSERT_OFF
  // The write-back of one slot never lands on the slot being read.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("slot write and read collide");

  // The sweep only touches slots in use.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CNT_W'(ram_waddr) < n_r))
    else $error("slot write beyond slots in use");

  // A set with zero leaves the store unstarted.
  a_set_zero_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_operation == OP_SET && in_set_value == '0) |=> !started_r)
    else $error("set with zero left the store started");

  // A drop means the total exceeded a limit, so it cannot be zero.
  a_drop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |-> (out_count_r != '0))
    else $error("drop reported with an empty window");
`endif

endmodule

/* rtl/swrl_ram.sv */
module swrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
